// ===== hdl/swseg_pkg.sv =====
// Shared types, constants and the segment table for the stopwatch display driver.
// Depends on nothing; every other module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package swseg_pkg;

   localparam int DIGITS         = 4;
   localparam int BITS_PER_DIGIT = 16;
   localparam int CNT_W          = 6;

   // Reciprocal of 600 scaled by 2^26; exact for every 16-bit time.
   localparam logic [16:0] MIN_RECIP     = 17'd111849;
   localparam int          MIN_SHIFT     = 26;
   localparam logic [9:0]  TENTH_PER_MIN = 10'd600;

   // Reciprocal of 10 scaled by 2^11; exact for values below 1029.
   localparam logic [7:0]  DIV10_RECIP = 8'd205;
   localparam int          DIV10_SHIFT = 11;
   localparam logic [3:0]  DEC_BASE    = 4'd10;

   // Four segment bytes, element 0 is the leftmost digit.
   typedef logic [DIGITS-1:0][7:0] seg_set_type;

   // Active-low segment code; bit 7 is the dot, cleared when the dot is lit.
   function automatic logic [7:0] seg_code(input logic [3:0] digit, input logic dot);
      logic [7:0] plain;
      case (digit)
         4'd0: plain = 8'hC0;
         4'd1: plain = 8'hF9;
         4'd2: plain = 8'hA4;
         4'd3: plain = 8'hB0;
         4'd4: plain = 8'h99;
         4'd5: plain = 8'h92;
         4'd6: plain = 8'h82;
         4'd7: plain = 8'hD8;
         4'd8: plain = 8'h80;
         4'd9: plain = 8'h90;
         default: plain = 8'hC0;
      endcase
      return dot ? {1'b0, plain[6:0]} : plain;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/swseg_front.sv =====
// Front end: accepts a request, splits the time into digits and encodes the segment bytes.
// Depends on swseg_pkg for the constants, the segment table and seg_set_type.
`timescale 1ns / 1ps
`default_nettype none

module swseg_front import swseg_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_time_tenths,
   input  wire logic        req_display_mode,
   output logic             seg_valid,
   input  wire logic        seg_ready,
   output seg_set_type      seg_set
);

   logic        en;
   logic        v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic        mode1_ff, mode2_ff, mode3_ff, mode4_ff, mode5_ff;
   logic [15:0] t1_ff, t2_ff;
   logic [6:0]  mins2_ff, mins3_ff;
   logic [9:0]  rem3_ff, rem4_ff;
   logic [3:0]  mt3_ff, mo4_ff, mo5_ff, mtm4_ff, mtm5_ff, tenths5_ff;
   logic [5:0]  st4_ff, st5_ff;
   logic [2:0]  sten5_ff;
   seg_set_type segs6_ff;

   logic [32:0] min_prod;
   logic [14:0] mt_prod;
   logic [17:0] st_prod;
   logic [13:0] sten_prod;
   logic [6:0]  mins2_in;
   logic [9:0]  rem3_in;
   logic [3:0]  mt3_in, mo4_in, mtm4_in, tenths5_in, sone;
   logic [5:0]  st4_in;
   logic [2:0]  sten5_in;
   seg_set_type segs6_in;

   // The whole pipeline moves together; it only holds while the result waits.
   assign en        = !v6_ff || seg_ready;
   assign req_ready = en;
   assign seg_valid = v6_ff;
   assign seg_set   = segs6_ff;

   always_comb begin
      min_prod   = 33'(t1_ff) * 33'(MIN_RECIP);
      mins2_in   = min_prod[MIN_SHIFT +: 7];

      rem3_in    = 10'(t2_ff - 16'(mins2_ff) * 16'(TENTH_PER_MIN));
      mt_prod    = 15'(mins2_ff) * 15'(DIV10_RECIP);
      mt3_in     = mt_prod[DIV10_SHIFT +: 4];

      st_prod    = 18'(rem3_ff) * 18'(DIV10_RECIP);
      st4_in     = st_prod[DIV10_SHIFT +: 6];
      mo4_in     = 4'(mins3_ff - 7'(mt3_ff) * 7'(DEC_BASE));
      // A hundred minutes or more wraps the tens digit.
      mtm4_in    = (mt3_ff == DEC_BASE) ? 4'd0 : mt3_ff;

      tenths5_in = 4'(rem4_ff - 10'(st4_ff) * 10'(DEC_BASE));
      sten_prod  = 14'(st4_ff) * 14'(DIV10_RECIP);
      sten5_in   = sten_prod[DIV10_SHIFT +: 3];

      sone       = 4'(st5_ff - 6'(sten5_ff) * 6'(DEC_BASE));
      if (!mode5_ff) begin
         segs6_in[0] = seg_code(mo5_ff, 1'b1);
         segs6_in[1] = seg_code({1'b0, sten5_ff}, 1'b0);
         segs6_in[2] = seg_code(sone, 1'b1);
         segs6_in[3] = seg_code(tenths5_ff, 1'b0);
      end else begin
         segs6_in[0] = seg_code(mtm5_ff, 1'b0);
         segs6_in[1] = seg_code(mo5_ff, 1'b1);
         segs6_in[2] = seg_code({1'b0, sten5_ff}, 1'b0);
         segs6_in[3] = seg_code(sone, 1'b0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff      <= req_time_tenths;
         mode1_ff   <= req_display_mode;
         t2_ff      <= t1_ff;
         mode2_ff   <= mode1_ff;
         mins2_ff   <= mins2_in;
         mode3_ff   <= mode2_ff;
         mins3_ff   <= mins2_ff;
         rem3_ff    <= rem3_in;
         mt3_ff     <= mt3_in;
         mode4_ff   <= mode3_ff;
         rem4_ff    <= rem3_ff;
         st4_ff     <= st4_in;
         mo4_ff     <= mo4_in;
         mtm4_ff    <= mtm4_in;
         mode5_ff   <= mode4_ff;
         st5_ff     <= st4_ff;
         sten5_ff   <= sten5_in;
         tenths5_ff <= tenths5_in;
         mo5_ff     <= mo4_ff;
         mtm5_ff    <= mtm4_ff;
         segs6_ff   <= segs6_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/swseg_fifo.sv =====
// Short queue of encoded digit sets between the front end and the serializer.
// Depends on swseg_pkg for seg_set_type.
`timescale 1ns / 1ps
`default_nettype none

module swseg_fifo import swseg_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire seg_set_type in_data,
   output logic             out_valid,
   input  wire logic        out_ready,
   output seg_set_type      out_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   seg_set_type    mem_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           push, pop;

   assign in_ready  = (cnt_ff != CW'(DEPTH));
   assign out_valid = (cnt_ff != CW'(0));
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? AW'(0) : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? AW'(0) : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/swseg_serial.sv =====
// Back end: shifts out each digit's segment byte and position byte, one bit per result.
// Depends on swseg_pkg for seg_set_type and the counter width CNT_W.
`timescale 1ns / 1ps
`default_nettype none

module swseg_serial import swseg_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   output logic             q_ready,
   input  wire seg_set_type q_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_serial_bit,
   output logic             rsp_latch_after,
   output logic             rsp_last
);

   logic             valid_ff, valid_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   seg_set_type      segs_ff;
   logic             fire, at_last, load;
   logic [1:0]       digit;
   logic [3:0]       bit_idx;
   logic [15:0]      word;

   assign digit   = cnt_ff[5:4];
   assign bit_idx = cnt_ff[3:0];
   assign word    = {segs_ff[digit], 8'b1 << digit};
   assign at_last = &cnt_ff;
   assign fire    = valid_ff && rsp_ready;
   assign q_ready = !valid_ff || (fire && at_last);
   assign load    = q_valid && q_ready;

   assign rsp_valid       = valid_ff;
   // Inverting the bit index walks the word from the MSB down.
   assign rsp_serial_bit  = word[~bit_idx];
   assign rsp_latch_after = &bit_idx;
   assign rsp_last        = at_last;

   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         valid_in = 1'b1;
         cnt_in   = '0;
      end else if (fire) begin
         valid_in = !at_last;
         cnt_in   = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         segs_ff <= q_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/stopwatch_time_to_segment_serial.sv =====
// Stopwatch time to seven-segment serial stream, top level.
// The first result bit is offered once a request has passed the front-end pipeline, the queue and the serializer.
// Throughput: 64 result bits per request, one per cycle from the serializer while rsp_ready is high;
// bits of consecutive requests follow with no gap when the next digit set is already queued.
// Reset clears the pipeline valid bits, the queue pointers and the bit counter.
// Depends on swseg_pkg, swseg_front, swseg_fifo and swseg_serial.
`timescale 1ns / 1ps
`default_nettype none

module stopwatch_time_to_segment_serial import swseg_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_time_tenths,
   input  wire logic        req_display_mode,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_serial_bit,
   output logic             rsp_latch_after,
   output logic             rsp_last
);

   logic        front_valid, front_ready;
   seg_set_type front_set;
   logic        queue_valid, queue_ready;
   seg_set_type queue_set;

   swseg_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_time_tenths  (req_time_tenths),
      .req_display_mode (req_display_mode),
      .seg_valid        (front_valid),
      .seg_ready        (front_ready),
      .seg_set          (front_set)
   );

   swseg_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_set),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_data  (queue_set)
   );

   swseg_serial u_serial (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (queue_valid),
      .q_ready         (queue_ready),
      .q_data          (queue_set),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_serial_bit  (rsp_serial_bit),
      .rsp_latch_after (rsp_latch_after),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the stopwatch seven-segment serial driver.
// Depends on swseg_pkg and stopwatch_time_to_segment_serial; a small scoreboard
// class predicts the 64-bit stream of every request and checks each result bit.
`timescale 1ns / 1ps

class segment_stream_scoreboard;
   typedef struct packed {
      logic serial_bit;
      logic latch_after;
      logic last;
   } stream_bit_type;

   stream_bit_type expected_bits[$];
   int mismatches;
   int checked;

   function new();
      mismatches = 0;
      checked = 0;
   endfunction

   // Active-low segment code of one decimal digit; clearing bit 7 lights the dot.
   static function logic [7:0] segment_byte(int unsigned digit, bit dot);
      logic [7:0] code;
      case (digit % 10)
         0: code = 8'hC0;
         1: code = 8'hF9;
         2: code = 8'hA4;
         3: code = 8'hB0;
         4: code = 8'h99;
         5: code = 8'h92;
         6: code = 8'h82;
         7: code = 8'hD8;
         8: code = 8'h80;
         default: code = 8'h90;
      endcase
      if (dot) code[7] = 1'b0;
      return code;
   endfunction

   function void note_request(logic [15:0] t, logic mode);
      int unsigned tenths;
      int unsigned secs;
      int unsigned mins;
      logic [7:0] segs [swseg_pkg::DIGITS];
      logic [15:0] word;
      stream_bit_type e;
      tenths = t % 10;
      secs = (t / 10) % 60;
      mins = t / 600;
      if (mode == 1'b0) begin
         segs[0] = segment_byte(mins % 10, 1'b1);
         segs[1] = segment_byte(secs / 10, 1'b0);
         segs[2] = segment_byte(secs % 10, 1'b1);
         segs[3] = segment_byte(tenths, 1'b0);
      end else begin
         // Tens of minutes wrap past 99 minutes.
         segs[0] = segment_byte((mins / 10) % 10, 1'b0);
         segs[1] = segment_byte(mins % 10, 1'b1);
         segs[2] = segment_byte(secs / 10, 1'b0);
         segs[3] = segment_byte(secs % 10, 1'b0);
      end
      for (int d = 0; d < swseg_pkg::DIGITS; d++) begin
         word = {segs[d], 8'h01 << d};
         for (int b = swseg_pkg::BITS_PER_DIGIT - 1; b >= 0; b--) begin
            e.serial_bit = word[b];
            e.latch_after = (b == 0);
            e.last = (d == swseg_pkg::DIGITS - 1) && (b == 0);
            expected_bits.push_back(e);
         end
      end
   endfunction

   function int pending();
      return expected_bits.size();
   endfunction

   task report(string what);
      if (mismatches < 30) $display("mismatch at result %0d: %s", checked, what);
      mismatches++;
   endtask

   task check_result(logic serial_bit, logic latch_after, logic last);
      stream_bit_type e;
      if (expected_bits.size() == 0) begin
         report($sformatf("result bit %b with no request pending", serial_bit));
      end else begin
         e = expected_bits.pop_front();
         if (serial_bit !== e.serial_bit)
            report($sformatf("serial_bit %b, expected %b", serial_bit, e.serial_bit));
         if (latch_after !== e.latch_after)
            report($sformatf("latch_after %b, expected %b", latch_after, e.latch_after));
         if (last !== e.last)
            report($sformatf("last %b, expected %b", last, e.last));
      end
      checked++;
   endtask
endclass

module testbench;
   localparam int IDLE_LIMIT  = 5000;
   localparam int HOLD_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   wire         req_ready;
   logic [15:0] req_time_tenths = 16'd0;
   logic        req_display_mode = 1'b0;
   wire         rsp_valid;
   logic        rsp_ready = 1'b0;
   wire         rsp_serial_bit;
   wire         rsp_latch_after;
   wire         rsp_last;

   int   sender_idle_pct = 22;
   int   receiver_idle_pct = 58;
   logic rsp_hold = 1'b0;

   segment_stream_scoreboard stream_check = new();

   stopwatch_time_to_segment_serial dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_time_tenths  (req_time_tenths),
      .req_display_mode (req_display_mode),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_serial_bit   (rsp_serial_bit),
      .rsp_latch_after  (rsp_latch_after),
      .rsp_last         (rsp_last)
   );

   always #5 clock = ~clock;

   // Receiver: checks every accepted bit and decides ready for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         stream_check.check_result(rsp_serial_bit, rsp_latch_after, rsp_last);
      rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   // Called at a clock edge; returns at the edge where the request is accepted.
   task automatic send_request(input logic [15:0] t, input logic mode);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_time_tenths <= t;
      req_display_mode <= mode;
      do @(posedge clock); while (!req_ready);
      stream_check.note_request(t, mode);
   endtask

   task automatic send_random(input int count);
      logic [15:0] t;
      int pick;
      repeat (count) begin
         pick = $urandom_range(0, 9);
         if (pick < 5)
            t = 16'($urandom_range(0, 65535));
         else if (pick < 7)
            t = 16'($urandom_range(0, 5999));
         else if (pick < 9)
            // Land on or just before a minute boundary.
            t = 16'(600 * $urandom_range(0, 108) + ($urandom_range(0, 1) ? 599 : 0));
         else
            t = 16'($urandom_range(60000, 65535));
         send_request(t, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (stream_check.pending() > 0) @(posedge clock);
   endtask

   task automatic hold_receiver();
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Field extremes, both layouts, and minute rollovers up to the wrap at 100 minutes.
      send_request(16'd0, 1'b0);
      send_request(16'd0, 1'b1);
      send_request(16'd65535, 1'b0);
      send_request(16'd65535, 1'b1);
      send_request(16'd9, 1'b0);
      send_request(16'd599, 1'b0);
      send_request(16'd599, 1'b1);
      send_request(16'd600, 1'b0);
      send_request(16'd600, 1'b1);
      send_request(16'd5999, 1'b0);
      send_request(16'd5999, 1'b1);
      send_request(16'd6000, 1'b0);
      send_request(16'd6000, 1'b1);
      send_request(16'd59999, 1'b0);
      send_request(16'd59999, 1'b1);
      send_request(16'd60000, 1'b0);
      send_request(16'd60000, 1'b1);
      send_request(16'd12345, 1'b0);
      send_request(16'd43210, 1'b1);
      send_random(30);
      wait_drained();

      sender_idle_pct = 58;
      receiver_idle_pct = 22;
      send_random(30);
      wait_drained();

      // No idling; a long receiver stall first backs the block up to its input.
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      hold_receiver();
      send_random(12);
      send_random(30);
      wait_drained();

      repeat (30) @(posedge clock);
      if (stream_check.pending() > 0)
         stream_check.report($sformatf("%0d result bits never came", stream_check.pending()));
      if (stream_check.mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
